@@ design/npq_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package npq_pkg;

    localparam int PALETTE_ENTRIES = 16;
    localparam int TABLE_SIZE      = 16;
    localparam int IDX_W           = 4;
    localparam int SUM_W           = 18;
    localparam int DIST_W          = 9;
    localparam int SQRT_STEPS      = 9;
    localparam int NUM_STAGES      = 2 * PALETTE_ENTRIES + SQRT_STEPS + 2;

    typedef struct packed {
        logic [7:0] chan_a;
        logic [7:0] chan_b;
        logic [7:0] chan_c;
    } in_beat_t;

    typedef struct packed {
        logic [IDX_W-1:0]  palette_index;
        logic [7:0]        out_red;
        logic [7:0]        out_green;
        logic [7:0]        out_blue;
        logic [DIST_W-1:0] best_distance;
    } out_beat_t;

    typedef struct packed {
        in_beat_t         pix;
        logic [SUM_W-1:0] min_sum;
    } min_bus_t;

    typedef struct packed {
        in_beat_t         pix;
        logic [SUM_W-1:0] rem;
        logic [SUM_W-1:0] root;
    } sqrt_bus_t;

    typedef struct packed {
        in_beat_t          pix;
        logic [SUM_W-1:0]  thr;
        logic [DIST_W-1:0] root_dist;
        logic              found;
        logic [IDX_W-1:0]  idx;
    } pick_bus_t;

    localparam logic [23:0] PAL_RGB [TABLE_SIZE] = '{
        24'h000000, 24'hFFFFFF, 24'h3A6616, 24'hACA65D,
        24'h814884, 24'hA47266, 24'h403286, 24'hBFB7E9,
        24'h6350A5, 24'h504400, 24'h699646, 24'h505050,
        24'h787878, 24'hE4B2A6, 24'h786ABD, 24'h9F9F9F
    };

    localparam logic [23:0] PAL_YUV [TABLE_SIZE] = '{
        24'h000000, 24'hFF0000, 24'h500000, 24'h9F000B,
        24'h60121D, 24'h800020, 24'h402200, 24'hBF1500,
        24'h602203, 24'h40000E, 24'h800000, 24'h500000,
        24'h780000, 24'hBF0020, 24'h782200, 24'h9F0000
    };

    function automatic logic [15:0] sq_diff(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] d;
        d = (a > b) ? (a - b) : (b - a);
        return 16'(d) * 16'(d);
    endfunction

    function automatic logic [SUM_W-1:0] color_sum(input in_beat_t pix,
                                                   input logic [IDX_W-1:0] entry,
                                                   input logic yuv);
        logic [23:0] row;
        row = yuv ? PAL_YUV[entry] : PAL_RGB[entry];
        return SUM_W'(sq_diff(row[23:16], pix.chan_a))
             + SUM_W'(sq_diff(row[15:8], pix.chan_b))
             + SUM_W'(sq_diff(row[7:0], pix.chan_c));
    endfunction

endpackage

`default_nettype wire

@@ design/npq_min_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none

module npq_min_cell (
    input  wire logic                       aclk,
    input  wire logic                       en,
    input  wire logic                       compare_in_yuv,
    input  wire logic [npq_pkg::IDX_W-1:0]  entry,
    input  wire npq_pkg::min_bus_t          bus_in,
    output npq_pkg::min_bus_t               bus_out
);

    npq_pkg::min_bus_t          bus_reg;
    npq_pkg::min_bus_t          bus_next;
    logic [npq_pkg::SUM_W-1:0]  sum;

    always_comb begin
        sum              = npq_pkg::color_sum(bus_in.pix, entry, compare_in_yuv);
        bus_next.pix     = bus_in.pix;
        bus_next.min_sum = (sum < bus_in.min_sum) ? sum : bus_in.min_sum;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            bus_reg <= bus_next;
        end
    end

    assign bus_out = bus_reg;

endmodule

`default_nettype wire

@@ design/npq_sqrt_stage.sv @@
`timescale 1ns / 1ps
`default_nettype none

module npq_sqrt_stage (
    input  wire logic                  aclk,
    input  wire logic                  en,
    input  wire logic [3:0]            step,
    input  wire npq_pkg::sqrt_bus_t    bus_in,
    output npq_pkg::sqrt_bus_t         bus_out
);

    npq_pkg::sqrt_bus_t         bus_reg;
    npq_pkg::sqrt_bus_t         bus_next;
    logic [npq_pkg::SUM_W-1:0]  bitv;
    logic [npq_pkg::SUM_W-1:0]  trial;

    always_comb begin
        bitv         = npq_pkg::SUM_W'(18'h10000) >> {step, 1'b0};
        trial        = bus_in.root + bitv;
        bus_next.pix = bus_in.pix;
        if (bus_in.rem >= trial) begin
            bus_next.rem  = bus_in.rem - trial;
            bus_next.root = (bus_in.root >> 1) + bitv;
        end else begin
            bus_next.rem  = bus_in.rem;
            bus_next.root = bus_in.root >> 1;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            bus_reg <= bus_next;
        end
    end

    assign bus_out = bus_reg;

endmodule

`default_nettype wire

@@ design/npq_pick_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none

module npq_pick_cell (
    input  wire logic                       aclk,
    input  wire logic                       en,
    input  wire logic                       compare_in_yuv,
    input  wire logic [npq_pkg::IDX_W-1:0]  entry,
    input  wire npq_pkg::pick_bus_t         bus_in,
    output npq_pkg::pick_bus_t              bus_out
);

    npq_pkg::pick_bus_t         bus_reg;
    npq_pkg::pick_bus_t         bus_next;
    logic [npq_pkg::SUM_W-1:0]  sum;
    logic                       hit;

    always_comb begin
        sum            = npq_pkg::color_sum(bus_in.pix, entry, compare_in_yuv);
        hit            = !bus_in.found && (sum < bus_in.thr);
        bus_next       = bus_in;
        bus_next.found = bus_in.found | hit;
        bus_next.idx   = hit ? entry : bus_in.idx;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            bus_reg <= bus_next;
        end
    end

    assign bus_out = bus_reg;

endmodule

`default_nettype wire

@@ design/nearest_palette_color_quantizer.sv @@
// Nearest palette color quantizer.
// One pixel beat enters on the s_ channel (s_valid, s_ready, s_data) and one
// result beat leaves on the m_ channel (m_valid, m_ready, m_data) carrying the
// index of the lowest palette entry whose floored Euclidean distance is the
// smallest (ties go to the lowest index), its RGB bytes and that distance.
// The cfg_ channel writes the compare_in_yuv mode bit; it is always ready and
// must be written only while no pixel is in flight.
// Throughput is one pixel per cycle unless the receiver stalls. One cell per
// entry finds the minimum squared sum, nine square-root stages floor it, one
// stage forms the threshold, a second row of one cell per entry picks the
// first entry under that threshold, and an output register holds the result.
// Reset clears every stage valid bit and sets the mode to RGB comparison.
// When the receiver stalls, the pipeline keeps accepting pixels until every
// stage holds a beat; each stage loads when it is empty or its successor moves.
`timescale 1ns / 1ps
`default_nettype none

module nearest_palette_color_quantizer (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire npq_pkg::in_beat_t   s_data,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output npq_pkg::out_beat_t       m_data,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic                cfg_wdata
);

    localparam int N   = npq_pkg::PALETTE_ENTRIES;
    localparam int D   = npq_pkg::NUM_STAGES;
    localparam int SQ0 = N;
    localparam int THR = N + npq_pkg::SQRT_STEPS;
    localparam int PK0 = THR + 1;
    localparam int OUT = D - 1;

    logic                 mode_reg;
    logic                 mode_next;
    logic [D-1:0]         vld_reg;
    logic [D-1:0]         vld_next;
    logic [D:0]           rdy;

    npq_pkg::min_bus_t    min_bus  [N+1];
    npq_pkg::sqrt_bus_t   sqrt_bus [npq_pkg::SQRT_STEPS+1];
    npq_pkg::pick_bus_t   pick_bus [N+1];
    npq_pkg::pick_bus_t   thr_reg;
    npq_pkg::pick_bus_t   thr_next;
    npq_pkg::out_beat_t   out_reg;
    npq_pkg::out_beat_t   out_next;
    logic [9:0]           dist_inc;
    logic [23:0]          rgb;

    assign cfg_ready = 1'b1;
    assign mode_next = (cfg_valid && cfg_ready) ? cfg_wdata : mode_reg;

    always_comb begin
        rdy[D] = m_ready;
        for (int i = D - 1; i >= 0; i--) begin
            rdy[i] = !vld_reg[i] || rdy[i+1];
        end
        for (int i = 0; i < D; i++) begin
            if (rdy[i]) begin
                vld_next[i] = (i == 0) ? s_valid : vld_reg[(i == 0) ? 0 : i - 1];
            end else begin
                vld_next[i] = vld_reg[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= 1'b0;
            vld_reg  <= '0;
        end else begin
            mode_reg <= mode_next;
            vld_reg  <= vld_next;
        end
    end

    assign s_ready = rdy[0];

    assign min_bus[0].pix     = s_data;
    assign min_bus[0].min_sum = '1;

    for (genvar j = 0; j < N; j++) begin : g_min
        npq_min_cell u_cell (
            .aclk           (aclk),
            .en             (rdy[j]),
            .compare_in_yuv (mode_reg),
            .entry          (npq_pkg::IDX_W'(j)),
            .bus_in         (min_bus[j]),
            .bus_out        (min_bus[j+1])
        );
    end

    assign sqrt_bus[0].pix  = min_bus[N].pix;
    assign sqrt_bus[0].rem  = min_bus[N].min_sum;
    assign sqrt_bus[0].root = '0;

    for (genvar k = 0; k < npq_pkg::SQRT_STEPS; k++) begin : g_sqrt
        npq_sqrt_stage u_stage (
            .aclk    (aclk),
            .en      (rdy[SQ0+k]),
            .step    (4'(k)),
            .bus_in  (sqrt_bus[k]),
            .bus_out (sqrt_bus[k+1])
        );
    end

    always_comb begin
        dist_inc           = 10'(sqrt_bus[npq_pkg::SQRT_STEPS].root[npq_pkg::DIST_W-1:0]) + 10'd1;
        thr_next.pix       = sqrt_bus[npq_pkg::SQRT_STEPS].pix;
        thr_next.root_dist = sqrt_bus[npq_pkg::SQRT_STEPS].root[npq_pkg::DIST_W-1:0];
        thr_next.thr       = npq_pkg::SUM_W'(20'(dist_inc) * 20'(dist_inc));
        thr_next.found     = 1'b0;
        thr_next.idx       = '0;
    end

    always_ff @(posedge aclk) begin
        if (rdy[THR]) begin
            thr_reg <= thr_next;
        end
    end

    assign pick_bus[0] = thr_reg;

    for (genvar j = 0; j < N; j++) begin : g_pick
        npq_pick_cell u_cell (
            .aclk           (aclk),
            .en             (rdy[PK0+j]),
            .compare_in_yuv (mode_reg),
            .entry          (npq_pkg::IDX_W'(j)),
            .bus_in         (pick_bus[j]),
            .bus_out        (pick_bus[j+1])
        );
    end

    always_comb begin
        rgb                    = npq_pkg::PAL_RGB[pick_bus[N].idx];
        out_next.palette_index = pick_bus[N].idx;
        out_next.out_red       = rgb[23:16];
        out_next.out_green     = rgb[15:8];
        out_next.out_blue      = rgb[7:0];
        out_next.best_distance = pick_bus[N].root_dist;
    end

    always_ff @(posedge aclk) begin
        if (rdy[OUT]) begin
            out_reg <= out_next;
        end
    end

    assign m_valid = vld_reg[OUT];
    assign m_data  = out_reg;

endmodule

`default_nettype wire
